### rtl/core/deq_pkg.sv
package deq_pkg;

  localparam int unsigned WordW = 32;

  // request kinds carried in the input tuser
  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } deq_req_e;

  // value reported for a missing word (empty queue, or a push)
  localparam logic [WordW-1:0] NoWord = '1;

endpackage

### rtl/core/deq_ram.sv
module deq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read-first: a read at the write address returns the old word
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

### rtl/core/double_ended_queue.sv
// An accepted request's result beat is registered in out_q, or in skid_q while an output beat waits.
// Throughput: one request per cycle; the result register plus one skid entry let one
// more request in while a result waits on m_axis_tready, then the input stalls.
// Front and back words live in registers; the words next to them are read each
// cycle from a two-read-port RAM, so every request finishes in one pass.
// Reset (rst_ni low, async): queue empty, pointers zero, no result pending; RAM not cleared.
module double_ended_queue #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [31:0]            s_axis_tdata,  // push_value
  input  logic [1:0]             s_axis_tuser,  // req_type

  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // popped_value, pop_was_empty, push_dropped, item_count, is_empty,
  // front_value, back_value, zero fill
  output logic [((3*32+3+$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned WordW = deq_pkg::WordW;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned RawW  = 3 * WordW + 3 + CntW;
  localparam int unsigned OutW  = ((RawW + 7) / 8) * 8;
  localparam int unsigned MaxW  = (DATA_WIDTH > WordW) ? DATA_WIDTH : WordW;
  localparam logic [AW-1:0]   LastIdx = AW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  function automatic logic [AW-1:0] idx_next(logic [AW-1:0] i);
    return (i == LastIdx) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_prev(logic [AW-1:0] i);
    return (i == '0) ? LastIdx : i - AW'(1);
  endfunction

  function automatic logic [DATA_WIDTH-1:0] to_store(logic [WordW-1:0] v);
    logic [MaxW-1:0] t;
    t = MaxW'(v);
    return t[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [WordW-1:0] to_word(logic [DATA_WIDTH-1:0] s);
    logic [MaxW-1:0] t;
    t = MaxW'(s);
    return t[WordW-1:0];
  endfunction

  logic [AW-1:0]         head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [DATA_WIDTH-1:0] front_q, front_d, back_q, back_d;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, raddr_f, raddr_b;
  logic [DATA_WIDTH-1:0] ram_wdata, rdata_f, rdata_b;
  logic                  byp_f_q, byp_b_q;
  logic [DATA_WIDTH-1:0] byp_data_q;
  logic [DATA_WIDTH-1:0] front2, back2;

  logic                  in_acc;
  deq_pkg::deq_req_e     req;
  logic                  q_empty, q_full;
  logic [WordW-1:0]      popped;
  logic                  pop_empty, dropped;
  logic [OutW-1:0]       result;

  logic                  out_v_q, skid_v_q;
  logic [OutW-1:0]       out_q, skid_q;

  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign req     = deq_pkg::deq_req_e'(s_axis_tuser);
  assign q_empty = (cnt_q == '0);
  assign q_full  = (cnt_q == FullCnt);

  // neighbors of the end entries, with the same-edge write forwarded
  assign front2 = byp_f_q ? byp_data_q : rdata_f;
  assign back2  = byp_b_q ? byp_data_q : rdata_b;

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    front_d   = front_q;
    back_d    = back_q;
    ram_we    = 1'b0;
    ram_waddr = tail_q;
    ram_wdata = to_store(s_axis_tdata);
    popped    = deq_pkg::NoWord;
    pop_empty = 1'b0;
    dropped   = 1'b0;
    if (in_acc) begin
      unique case (req)
        deq_pkg::REQ_PUSH_FRONT: begin
          if (q_full) begin
            dropped = 1'b1;
          end else begin
            head_d    = idx_prev(head_q);
            ram_we    = 1'b1;
            ram_waddr = head_d;
            front_d   = ram_wdata;
            if (q_empty) back_d = ram_wdata;
            cnt_d     = cnt_q + CntW'(1);
          end
        end
        deq_pkg::REQ_PUSH_BACK: begin
          if (q_full) begin
            dropped = 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = tail_q;
            tail_d    = idx_next(tail_q);
            back_d    = ram_wdata;
            if (q_empty) front_d = ram_wdata;
            cnt_d     = cnt_q + CntW'(1);
          end
        end
        deq_pkg::REQ_POP_FRONT: begin
          if (q_empty) begin
            pop_empty = 1'b1;
          end else begin
            popped  = to_word(front_q);
            head_d  = idx_next(head_q);
            front_d = front2;
            cnt_d   = cnt_q - CntW'(1);
          end
        end
        deq_pkg::REQ_POP_BACK: begin
          if (q_empty) begin
            pop_empty = 1'b1;
          end else begin
            popped = to_word(back_q);
            tail_d = idx_prev(tail_q);
            back_d = back2;
            cnt_d  = cnt_q - CntW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign raddr_f = idx_next(head_d);
  assign raddr_b = idx_prev(idx_prev(tail_d));

  always_comb begin
    logic [WordW-1:0] fw, bw;
    fw = (cnt_d == '0) ? deq_pkg::NoWord : to_word(front_d);
    bw = (cnt_d == '0) ? deq_pkg::NoWord : to_word(back_d);
    result = OutW'({bw, fw, (cnt_d == '0), cnt_d, dropped, pop_empty, popped});
  end

  deq_ram #(
    .Width(DATA_WIDTH),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr_a_i(raddr_f),
    .rdata_a_o(rdata_f),
    .raddr_b_i(raddr_b),
    .rdata_b_o(rdata_b)
  );

  always_ff @(posedge clk_i) begin
    byp_data_q <= ram_wdata;
    front_q    <= front_d;
    back_q     <= back_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      byp_f_q <= 1'b0;
      byp_b_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      byp_f_q <= ram_we && (ram_waddr == raddr_f);
      byp_b_q <= ram_we && (ram_waddr == raddr_b);
    end
  end

  // result register with one skid entry behind it
  assign s_axis_tready = !skid_v_q;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || m_axis_tready) begin
      out_v_q  <= skid_v_q || in_acc;
      skid_v_q <= 1'b0;
    end else if (in_acc) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || m_axis_tready) begin
      out_q <= skid_v_q ? skid_q : result;
    end else if (in_acc) begin
      skid_q <= result;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("entry count above depth");

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held with empty result register");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !s_axis_tuser[1] && !q_full) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("accepted push did not raise the count");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (head_q == tail_q))
    else $error("empty queue with head and tail apart");

endmodule
